FILE: sv/fev_pkg.sv
// ============================================================================
// fev_pkg
// Shared types and constants for the FIR equalizer with volume stage.
// ============================================================================
`default_nettype none

package fev_pkg;

   localparam int TAPS_DEF    = 128;
   localparam int SAMPLE_W    = 16;
   localparam int COEF_W      = 16;
   localparam int GAIN_W      = 16;
   localparam int TAP_IDX_W   = 7;
   localparam int ACC_W       = 32;
   localparam int MUL_IN_W    = 17;
   localparam int MUL_OUT_W   = 2 * MUL_IN_W;
   localparam int ACC_SHIFT   = 16;
   localparam int GAIN_SHIFT  = 14;

   localparam logic FUNC_FILTER    = 1'b0;
   localparam logic FUNC_TAP_WRITE = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_OUT
   } fev_state_type;

endpackage

`default_nettype wire

FILE: sv/fir_equalizer_with_volume.sv
// ============================================================================
// fir_equalizer_with_volume
// Direct-form FIR over a sample ring with one shared multiplier, plus volume.
// ============================================================================
// A sample transfer (func 0) is filtered against the previous TAPS samples by a
// single 17x17 multiplier that steps through the history and weight memories,
// one tap per cycle, and is then reused once for the volume gain. From its
// transfer to the result being registered, a sample passes through TAPS
// multiply-accumulate steps, a drain of the registered memory read, product
// and accumulate, one volume multiply and the load of the output register;
// the input stalls for that whole time, and longer while a previous result
// still waits in the output register. A tap write (func 1) gives no result.
// After reset both memories are zeroed by a clearing pass over all TAPS
// entries, during which no input is taken; csr writes are taken at any time.
// A finished result sits in an output register, so the next input can be
// taken while it waits.
`default_nettype none

module fir_equalizer_with_volume
   import fev_pkg::*;
#(
   parameter int TAPS = TAPS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_wr_en,
   input  wire logic [GAIN_W-1:0]            csr_wr_data,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic                         req_func,
   input  wire logic signed [SAMPLE_W-1:0]   req_sample_in,
   input  wire logic [TAP_IDX_W-1:0]         req_tap_index,
   input  wire logic signed [COEF_W-1:0]     req_tap_weight,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed [SAMPLE_W-1:0]        rsp_sample_out
);

   localparam int IW = $clog2(TAPS);
   localparam int CW = ((IW > TAP_IDX_W) ? IW : TAP_IDX_W) + 1;
   localparam logic [IW-1:0] LAST = IW'(TAPS - 1);

   // memories
   logic [SAMPLE_W-1:0] hist_mem [TAPS];
   logic [COEF_W-1:0]   wt_mem   [TAPS];

   fev_state_type state_ff, state_in;

   logic [IW-1:0]       clr_ff, clr_in;
   logic [IW-1:0]       pos_ff, pos_in;
   logic [IW-1:0]       k_ff, k_in;
   logic [IW-1:0]       slot_ff, slot_in;
   logic [GAIN_W-1:0]   gain_ff;
   logic [SAMPLE_W-1:0] sample_ff;
   logic                rd_vld_ff, rd_vld_in;
   logic                mul_vld_ff;
   logic [SAMPLE_W-1:0] hist_q;
   logic [COEF_W-1:0]   wt_q;
   logic signed [MUL_OUT_W-1:0] prod_ff;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_data_ff;

   logic                req_xfer;
   logic                tap_in_range;
   logic                hist_we, wt_we;
   logic [IW-1:0]       hist_waddr, wt_waddr;
   logic [SAMPLE_W-1:0] hist_wdata;
   logic [COEF_W-1:0]   wt_wdata;
   logic                vol_sel, mul_en;
   logic                out_load;
   logic signed [MUL_IN_W-1:0] mul_a, mul_b;

   assign req_stall      = (state_ff != ST_IDLE);
   assign req_xfer       = req_valid && !req_stall;
   assign tap_in_range   = (CW'(req_tap_index) < CW'(TAPS));
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

   // shared multiplier operand select: taps while running, gain at the end
   assign vol_sel = (state_ff == ST_DRAIN) && !rd_vld_ff && !mul_vld_ff;
   assign mul_en  = rd_vld_ff || vol_sel;
   always_comb begin
      if (vol_sel) begin
         mul_a = MUL_IN_W'($signed(acc_ff[ACC_W-1:ACC_SHIFT]));
         mul_b = $signed({1'b0, gain_ff});
      end else begin
         mul_a = MUL_IN_W'($signed(hist_q));
         mul_b = MUL_IN_W'($signed(wt_q));
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      pos_in       = pos_ff;
      k_in         = k_ff;
      slot_in      = slot_ff;
      rd_vld_in    = 1'b0;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      out_load     = 1'b0;
      hist_we      = 1'b0;
      hist_waddr   = pos_ff;
      hist_wdata   = sample_ff;
      wt_we        = 1'b0;
      wt_waddr     = IW'(req_tap_index);
      wt_wdata     = req_tap_weight;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (mul_vld_ff) begin
         acc_in = acc_ff + prod_ff[ACC_W-1:0];
      end

      case (state_ff)
         ST_CLEAR: begin
            hist_we    = 1'b1;
            hist_waddr = clr_ff;
            hist_wdata = '0;
            wt_we      = 1'b1;
            wt_waddr   = clr_ff;
            wt_wdata   = '0;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_func == FUNC_TAP_WRITE) begin
                  wt_we = tap_in_range;
               end else begin
                  k_in     = '0;
                  slot_in  = pos_ff;
                  acc_in   = '0;
                  state_in = ST_MAC;
               end
            end
         end
         ST_MAC: begin
            rd_vld_in = 1'b1;
            k_in      = k_ff + 1'b1;
            slot_in   = (slot_ff == LAST) ? '0 : slot_ff + 1'b1;
            if (k_ff == LAST) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (vol_sel) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load     = 1'b1;
               rsp_valid_in = 1'b1;
               // newest sample replaces the oldest
               hist_we      = 1'b1;
               pos_in       = (pos_ff == LAST) ? '0 : pos_ff + 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pos_ff       <= '0;
         gain_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         mul_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pos_ff       <= pos_in;
         rd_vld_ff    <= rd_vld_in;
         mul_vld_ff   <= rd_vld_ff;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            gain_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      slot_ff <= slot_in;
      acc_ff  <= acc_in;
      if (req_xfer && req_func == FUNC_FILTER) begin
         sample_ff <= req_sample_in;
      end
      if (mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
      if (out_load) begin
         rsp_data_ff <= prod_ff[GAIN_SHIFT+SAMPLE_W-1:GAIN_SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_waddr] <= hist_wdata;
      end
      hist_q <= hist_mem[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (wt_we) begin
         wt_mem[wt_waddr] <= wt_wdata;
      end
      wt_q <= wt_mem[k_ff];
   end

   // assertions
   a_rd_in_run: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (state_ff == ST_MAC || state_ff == ST_DRAIN))
      else $error("memory read in flight outside the MAC phase");

   a_mac_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC && k_ff == LAST) |=> state_ff == ST_DRAIN)
      else $error("MAC phase did not end after the last tap");

   a_ring_wrap: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN |-> slot_ff == pos_ff)
      else $error("history pointer did not wrap back to the oldest sample");

   a_out_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT |-> (!rd_vld_ff && !mul_vld_ff))
      else $error("result stage reached with products still in flight");

endmodule

`default_nettype wire
